// ===== sv/ipu_pkg.sv =====
// Shared types and constants for the integer pixel upscaler.
// Holds the beat payload structs, register codes and the command format
// passed from the front end to the back end. No dependencies.
package ipu_pkg;

    localparam int PIXEL_W    = 24;
    localparam int SCALE_W    = 5;
    localparam int WIDTH_W    = 12;
    localparam int COL_W      = 11;
    localparam int REPLAY_W   = 4;
    localparam int PAD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_REPLAY = 1'b1;

    typedef struct packed {
        logic               action;
        logic [PIXEL_W-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               row_end;
        logic [PAD_W-1:0]   pad_bytes;
        logic               refused;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic [PAD_W-1:0]   pad_bytes;
        logic               refused;
        logic [SCALE_W-1:0] reps;
    } cmd_t;

endpackage

// ===== sv/ipu_front.sv =====
// Front end of the upscaler: configuration registers, phase tracking,
// the line buffer and one command stage that feeds the command queue.
// Depends on ipu_pkg.
module ipu_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  ipu_pkg::in_item_t                item,
    input  logic                             wr_en,
    input  logic [ipu_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ipu_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                             q_full,
    output logic                             q_push,
    output ipu_pkg::cmd_t                    q_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = ipu_pkg::WIDTH_W + 1;
    localparam int WIDTH_MAX_VAL = (1 << ipu_pkg::WIDTH_W) - 1;
    localparam int SCALE_MAX_VAL = (1 << ipu_pkg::SCALE_W) - 1;
    localparam logic [ipu_pkg::WIDTH_W-1:0] WIDTH_CAP =
        ipu_pkg::WIDTH_W'((MAX_WIDTH > WIDTH_MAX_VAL) ? WIDTH_MAX_VAL : MAX_WIDTH);
    localparam logic [ipu_pkg::SCALE_W-1:0] SCALE_CAP =
        ipu_pkg::SCALE_W'((MAX_SCALE > SCALE_MAX_VAL) ? SCALE_MAX_VAL : MAX_SCALE);

    logic [ipu_pkg::SCALE_W-1:0]  scale_reg;
    logic [ipu_pkg::WIDTH_W-1:0]  width_reg;
    logic [ipu_pkg::COL_W-1:0]    column_reg;
    logic [ipu_pkg::COL_W-1:0]    column_next;
    logic [ipu_pkg::REPLAY_W-1:0] replays_reg;
    logic [ipu_pkg::REPLAY_W-1:0] replays_next;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_push_reg;
    ipu_pkg::cmd_t                s1_cmd_reg;
    ipu_pkg::cmd_t                s1_cmd_next;
    logic [ipu_pkg::PIXEL_W-1:0]  rd_data_reg;
    logic [ipu_pkg::PIXEL_W-1:0]  line_buffer [MAX_WIDTH];

    logic [ipu_pkg::SCALE_W-1:0]  eff_scale;
    logic [ipu_pkg::WIDTH_W-1:0]  eff_width;
    logic [AW-1:0]                addr;
    logic                         accept;
    logic                         refused;
    logic                         ends;
    logic [ipu_pkg::PAD_W-1:0]    pad_prod;
    logic [ipu_pkg::PAD_W-1:0]    pad;
    logic                         is_push;

    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = ipu_pkg::SCALE_W'(1);
        else if (scale_reg > SCALE_CAP)
            eff_scale = SCALE_CAP;
        else
            eff_scale = scale_reg;

        if (width_reg == '0)
            eff_width = ipu_pkg::WIDTH_W'(1);
        else if (width_reg > WIDTH_CAP)
            eff_width = WIDTH_CAP;
        else
            eff_width = width_reg;
    end

    assign addr     = AW'(column_reg);
    assign is_push  = (item.action == ipu_pkg::ACT_PUSH);
    assign refused  = is_push != (replays_reg == '0);
    assign ends     = (CW'(column_reg) + CW'(1)) >= CW'(eff_width);
    assign pad_prod = 2'd3 * eff_width[1:0] * eff_scale[1:0];
    assign pad      = 2'd0 - pad_prod;

    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        column_next  = column_reg;
        replays_next = replays_reg;
        if (accept && !refused)
        begin
            if (ends)
            begin
                column_next = '0;
                if (is_push)
                    replays_next = ipu_pkg::REPLAY_W'(eff_scale - ipu_pkg::SCALE_W'(1));
                else
                    replays_next = replays_reg - ipu_pkg::REPLAY_W'(1);
            end
            else
            begin
                column_next = column_reg + ipu_pkg::COL_W'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = accept || (s1_valid_reg && q_full);
        s1_cmd_next.pixel     = item.pixel;
        s1_cmd_next.row_end   = ends && !refused;
        s1_cmd_next.pad_bytes = pad;
        s1_cmd_next.refused   = refused;
        s1_cmd_next.reps      = refused ? ipu_pkg::SCALE_W'(1) : eff_scale;
    end

    always_comb
    begin
        q_data = s1_cmd_reg;
        if (s1_cmd_reg.refused)
            q_data.pixel = '0;
        else if (s1_push_reg)
            q_data.pixel = s1_cmd_reg.pixel;
        else
            q_data.pixel = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= ipu_pkg::SCALE_W'(1);
            width_reg    <= ipu_pkg::WIDTH_W'(1);
            column_reg   <= '0;
            replays_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == ipu_pkg::CFG_SCALE)
                    scale_reg <= wr_data[ipu_pkg::SCALE_W-1:0];
                else
                    width_reg <= wr_data[ipu_pkg::WIDTH_W-1:0];
            end
            column_reg   <= column_next;
            replays_reg  <= replays_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= s1_cmd_next;
            s1_push_reg <= is_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !refused && is_push)
            line_buffer[addr] <= item.pixel;
        if (accept)
            rd_data_reg <= line_buffer[addr];
    end

endmodule

// ===== sv/ipu_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on ipu_pkg for the command format.
module ipu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  ipu_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output ipu_pkg::cmd_t head
);

    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    ipu_pkg::cmd_t slots_reg [2];
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// ===== sv/ipu_back.sv =====
// Back end of the upscaler: takes one command at a time from the queue
// and sends its pixel out as many times as the command asks, one per beat.
// Depends on ipu_pkg.
module ipu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ipu_pkg::cmd_t      head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output ipu_pkg::out_item_t result
);

    logic                        valid_reg;
    logic                        valid_next;
    ipu_pkg::cmd_t               cur_reg;
    logic [ipu_pkg::SCALE_W-1:0] sent_reg;
    logic [ipu_pkg::SCALE_W-1:0] sent_next;
    logic                        fin;
    logic                        taken;
    logic                        load;

    assign fin   = (sent_reg == cur_reg.reps - ipu_pkg::SCALE_W'(1));
    assign taken = pop && valid_reg;
    assign load  = !valid_reg || (taken && fin);
    assign q_pop = load && !q_empty;
    assign empty = !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        sent_next  = sent_reg;
        if (load)
        begin
            valid_next = !q_empty;
            sent_next  = '0;
        end
        else if (taken)
        begin
            sent_next = sent_reg + ipu_pkg::SCALE_W'(1);
        end
    end

    always_comb
    begin
        result.out_pixel = cur_reg.pixel;
        result.row_end   = fin && cur_reg.row_end;
        result.pad_bytes = (fin && cur_reg.row_end) ? cur_reg.pad_bytes : '0;
        result.refused   = cur_reg.refused;
        result.last      = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= head;
    end

endmodule

// ===== sv/integer_pixel_upscaler.sv =====
// An accepted push beat stores its pixel in the line buffer and yields scale result
// beats of that pixel; once a source row is in, replay beats resend buffered pixels
// until each row has gone out scale times, and a beat in the wrong phase yields one
// refused result. The input side takes one beat per cycle while the two-entry command
// queue has room; the output side delivers one result per cycle while pop is held, so
// a steady stream is paced by the back end, which repeats each pixel scale times and
// sends a refused item once. An accepted item passes the front-end command stage, a
// queue slot and the back-end command register before its result is on the output
// ports. Top level; depends on ipu_pkg, ipu_front, ipu_queue and ipu_back.
module integer_pixel_upscaler #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  ipu_pkg::in_item_t               item,
    output logic                            empty,
    input  logic                            pop,
    output ipu_pkg::out_item_t              result,
    input  logic                            wr_en,
    input  logic [ipu_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ipu_pkg::CFG_DATA_W-1:0]  wr_data
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    ipu_pkg::cmd_t q_data;
    ipu_pkg::cmd_t q_head;

    ipu_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    ipu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_cmd  (q_data),
        .q_full  (q_full),
        .rd      (q_pop),
        .q_empty (q_empty),
        .head    (q_head)
    );

    ipu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== sv/ipu_checker.sv =====
// Port-level checks on the result side of the upscaler, and the bind
// that attaches them to the top level. Depends on ipu_pkg.
module ipu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input ipu_pkg::out_item_t result
);

    a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.refused) |-> (result.last && !result.row_end))
        else $error("refused beat must be a single final beat without row end");

    a_refused_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.refused) |-> (result.out_pixel == '0))
        else $error("refused beat carries a pixel");

    a_pad_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.pad_bytes != '0)) |-> result.row_end)
        else $error("pad bytes outside a row end");

    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.row_end) |-> result.last)
        else $error("row end on a beat that is not the last of its item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind integer_pixel_upscaler ipu_checker u_ipu_checker (.*);

// ===== tb/tb_integer_pixel_upscaler.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for integer_pixel_upscaler: directed rows, then random rows
// under random stalls and in steady stretches, each beat compared with a built-in predictor of the upscaler.
// Depends on ipu_pkg and the integer_pixel_upscaler RTL.
module tb_integer_pixel_upscaler;

    localparam int MAX_WIDTH = 2048;
    localparam int MAX_SCALE = 16;
    localparam int NUM_ITEMS = 270;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    ipu_pkg::in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    ipu_pkg::out_item_t result;
    logic wr_en = 1'b0;
    logic [ipu_pkg::CFG_IDX_W-1:0] wr_index = ipu_pkg::CFG_SCALE;
    logic [ipu_pkg::CFG_DATA_W-1:0] wr_data = '0;

    ipu_pkg::in_item_t source_beats[$];
    ipu_pkg::out_item_t upscaled_beats[$];
    ipu_pkg::out_item_t oldest;
    int unsigned mismatches = 0;
    int unsigned sent_items = 0;
    bit steady = 1'b0;

    logic [ipu_pkg::SCALE_W-1:0] scale_reg = 5'd1;
    logic [ipu_pkg::WIDTH_W-1:0] width_reg = 12'd1;
    logic [ipu_pkg::PIXEL_W-1:0] line_buffer [MAX_WIDTH];
    bit buffer_written [MAX_WIDTH];
    logic [ipu_pkg::COL_W-1:0] column = '0;
    logic [ipu_pkg::REPLAY_W-1:0] replays_left = '0;

    integer_pixel_upscaler #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_SCALE(MAX_SCALE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_scale(logic [ipu_pkg::SCALE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_SCALE)
            return MAX_SCALE;
        return 32'(s);
    endfunction

    function automatic int unsigned eff_width(logic [ipu_pkg::WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(w);
    endfunction

    function automatic bit rows_written(int unsigned w);
        for (int i = 0; i < w; i++)
        begin
            if (!buffer_written[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Appends the result beats of one input beat and returns 1 unless it is refused.
    function automatic bit upscale_item(ipu_pkg::in_item_t beat);
        int unsigned s;
        int unsigned w;
        int unsigned idx;
        int unsigned pad;
        bit ends;
        logic [ipu_pkg::PIXEL_W-1:0] pix;
        ipu_pkg::out_item_t r;
        s = eff_scale(scale_reg);
        w = eff_width(width_reg);
        idx = column % MAX_WIDTH;
        r = '0;
        if ((beat.action == ipu_pkg::ACT_PUSH) != (replays_left == 0))
        begin
            r.refused = 1'b1;
            r.last = 1'b1;
            upscaled_beats.push_back(r);
            return 1'b0;
        end
        if (beat.action == ipu_pkg::ACT_PUSH)
        begin
            line_buffer[idx] = beat.pixel;
            buffer_written[idx] = 1'b1;
            pix = beat.pixel;
        end
        else
            pix = line_buffer[idx];
        ends = (idx + 1 >= w);
        pad = (4 - (3 * w * s) % 4) % 4;
        for (int k = 0; k < s; k++)
        begin
            r = '0;
            r.out_pixel = pix;
            r.last = (k + 1 == s);
            r.row_end = r.last && ends;
            r.pad_bytes = r.row_end ? ipu_pkg::PAD_W'(pad) : '0;
            upscaled_beats.push_back(r);
        end
        if (ends)
        begin
            column = '0;
            if (beat.action == ipu_pkg::ACT_PUSH)
                replays_left = ipu_pkg::REPLAY_W'(s - 1);
            else
                replays_left = replays_left - ipu_pkg::REPLAY_W'(1);
        end
        else
            column = ipu_pkg::COL_W'(idx + 1);
        return 1'b1;
    endfunction

    function automatic void send(logic action, logic [ipu_pkg::PIXEL_W-1:0] pixel);
        ipu_pkg::in_item_t beat;
        bit taken;
        beat.action = action;
        beat.pixel = pixel;
        source_beats.push_back(beat);
        taken = upscale_item(beat);
        sent_items++;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic drain();
        while (source_beats.size() != 0 || push || upscaled_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_regs(logic [ipu_pkg::SCALE_W-1:0] s,
                                logic [ipu_pkg::WIDTH_W-1:0] w);
        drain();
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= ipu_pkg::CFG_SCALE;
        wr_data <= ipu_pkg::CFG_DATA_W'(s);
        scale_reg = s;
        @(posedge clk);
        wr_index <= ipu_pkg::CFG_WIDTH;
        wr_data <= w;
        width_reg = w;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else if (!push || !full)
        begin
            if (source_beats.size() != 0 && (steady || $urandom_range(99) >= 35))
            begin
                item <= source_beats.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (upscaled_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    oldest = upscaled_beats.pop_front();
                    check_field("out_pixel", 32'(oldest.out_pixel), 32'(result.out_pixel));
                    check_field("row_end", 32'(oldest.row_end), 32'(result.row_end));
                    check_field("pad_bytes", 32'(oldest.pad_bytes), 32'(result.pad_bytes));
                    check_field("refused", 32'(oldest.refused), 32'(result.refused));
                    check_field("last", 32'(oldest.last), 32'(result.last));
                end
            end
            pop <= steady || $urandom_range(99) >= 35;
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned run;
        int unsigned phase;
        logic [ipu_pkg::SCALE_W-1:0] new_scale;
        logic [ipu_pkg::WIDTH_W-1:0] new_width;
        logic right_action;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // A two-pixel row at scale 3 with wrong-phase beats on both sides.
        program_regs(5'd3, 12'd2);
        send(ipu_pkg::ACT_REPLAY, 24'h123456);
        send(ipu_pkg::ACT_PUSH, 24'h000000);
        send(ipu_pkg::ACT_PUSH, 24'hFFFFFF);
        send(ipu_pkg::ACT_PUSH, 24'hA5A5A5);
        repeat (4) send(ipu_pkg::ACT_REPLAY, ipu_pkg::PIXEL_W'($urandom));

        // Zero registers act as one, so a single push completes the image row.
        program_regs(5'd0, 12'd0);
        send(ipu_pkg::ACT_PUSH, 24'h5A5A5A);
        send(ipu_pkg::ACT_REPLAY, 24'hFFFFFF);

        // Oversized registers clamp; the row is then cut short by a smaller width.
        program_regs(5'd31, 12'hFFF);
        repeat (3) send(ipu_pkg::ACT_PUSH, ipu_pkg::PIXEL_W'($urandom));
        program_regs(5'd2, 12'd2);
        send(ipu_pkg::ACT_PUSH, ipu_pkg::PIXEL_W'($urandom));
        repeat (2) send(ipu_pkg::ACT_REPLAY, ipu_pkg::PIXEL_W'($urandom));

        phase = 0;
        while (sent_items < NUM_ITEMS)
        begin
            run = $urandom_range(4, 40);
            if (run > NUM_ITEMS - sent_items)
                run = NUM_ITEMS - sent_items;
            repeat (run)
            begin
                right_action = (replays_left != 0) ? ipu_pkg::ACT_REPLAY : ipu_pkg::ACT_PUSH;
                if ($urandom_range(99) < 10)
                    send(~right_action, ipu_pkg::PIXEL_W'($urandom));
                else
                    send(right_action, ipu_pkg::PIXEL_W'($urandom));
            end
            if (phase == 7 || phase == 13 || $urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    new_scale = 5'd0;
                else if (pick < 16)
                    new_scale = ipu_pkg::SCALE_W'($urandom_range(17, 31));
                else if (pick < 24)
                    new_scale = 5'd16;
                else
                    new_scale = ipu_pkg::SCALE_W'($urandom_range(1, 6));
                pick = $urandom_range(99);
                if (eff_scale(new_scale) > 6)
                    new_width = ipu_pkg::WIDTH_W'($urandom_range(0, 3));
                else if (pick < 6)
                    new_width = 12'd0;
                else if (pick < 12)
                    new_width = ipu_pkg::WIDTH_W'($urandom_range(2049, 4095));
                else if (pick < 16)
                    new_width = 12'd2048;
                else if (pick < 26)
                    new_width = ipu_pkg::WIDTH_W'($urandom_range(13, 40));
                else
                    new_width = ipu_pkg::WIDTH_W'($urandom_range(1, 12));
                // While rows are being replayed, the width may only cover stored pixels.
                if (replays_left != 0 && !rows_written(eff_width(new_width)))
                    new_width = width_reg;
                program_regs(new_scale, new_width);
                steady = (phase >= 7 && phase < 13);
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ipu_pkg.sv
sv/ipu_front.sv
sv/ipu_queue.sv
sv/ipu_back.sv
sv/integer_pixel_upscaler.sv
sv/ipu_checker.sv
tb/tb_integer_pixel_upscaler.sv
